/* rtl/pgmp_pkg.sv */
package pgmp_pkg;

	// Default sizing
	localparam int unsigned MaxSideDefault  = 4096;
	localparam int unsigned ValueBitsDefault = 16;

	// ASCII codes the parser recognizes
	localparam logic [7:0] ChP       = 8'h50; // 'P'
	localparam logic [7:0] ChTwo     = 8'h32; // '2'
	localparam logic [7:0] ChHash    = 8'h23; // '#'
	localparam logic [7:0] ChZero    = 8'h30; // '0'
	localparam logic [7:0] ChNine    = 8'h39; // '9'
	localparam logic [7:0] ChNewline = 8'h0A; // '\n'
	localparam logic [7:0] ChTab     = 8'h09;
	localparam logic [7:0] ChVtab    = 8'h0B;
	localparam logic [7:0] ChFfeed   = 8'h0C;
	localparam logic [7:0] ChCr      = 8'h0D;
	localparam logic [7:0] ChSpace   = 8'h20;

	// Line position codes
	localparam logic [1:0] LposStart  = 2'd0;
	localparam logic [1:0] LposSecond = 2'd1;
	localparam logic [1:0] LposRest   = 2'd2;

	// One result word as it leaves the block
	typedef struct packed {
		logic [15:0] pixel_value;
		logic [11:0] column;
		logic [11:0] row;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] max_grey;
		logic        error_flag;
	} pixel_t;

	// Result of one parser step
	typedef struct packed {
		logic   hit;
		pixel_t pix;
	} step_res_t;

endpackage

/* rtl/pgm_ascii_stream_parser.sv */
// Streaming parser for ASCII P2 greymaps. Feed the file text one byte per word
// on the input channel, with file_start high on the first byte of each file to
// clear the parser. Comment lines starting with '#' are skipped anywhere; text
// before a line starting with "P2" is ignored; then come the size line and the
// maximum grey line, and every whitespace-terminated decimal value after that
// leaves as one output word with its column, row and the header fields. The
// error flag is sticky per file: it marks non-digit bytes, values that
// saturate, oversized sides and pixels below the last row. The block takes one
// byte every cycle and gives at most one word per byte; an accepted byte is
// held in the input register before its word is written to the output
// register. That rate is set by the parser state (phase, accumulator, column
// and row counters), which is updated once per byte between the input
// register and the output register. The input is stalled only while a pixel
// is ready and the output register is still held by a stalled word.
module pgm_ascii_stream_parser #(
	parameter int unsigned MAX_SIDE   = pgmp_pkg::MaxSideDefault,
	parameter int unsigned VALUE_BITS = pgmp_pkg::ValueBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_value,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic [12:0] image_width_out,
	output logic [12:0] image_height_out,
	output logic [15:0] max_grey,
	output logic        error_flag
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Output register
	logic             valid_s2;
	pgmp_pkg::pixel_t pix_s2;

	pgmp_pkg::step_res_t step;
	logic                advance;
	logic                in_take;

	pgmp_parser #(
		.MAX_SIDE   (MAX_SIDE),
		.VALUE_BITS (VALUE_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.byte_in    (byte_s1),
		.file_start (start_s1),
		.res        (step)
	);

	// Advance the held byte unless it yields a pixel and the output word is stuck
	assign advance  = valid_s1 && (!step.hit || !valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= byte_in;
			start_s1 <= file_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && step.hit) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.hit) begin
			pix_s2 <= step.pix;
		end
	end

	assign out_valid        = valid_s2;
	assign pixel_value      = pix_s2.pixel_value;
	assign column           = pix_s2.column;
	assign row              = pix_s2.row;
	assign image_width_out  = pix_s2.image_width;
	assign image_height_out = pix_s2.image_height;
	assign max_grey         = pix_s2.max_grey;
	assign error_flag       = pix_s2.error_flag;

	// A stall toward the input only ever comes from a byte held in stage one
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no byte held");

	// A pending pixel must wait while the output word is stuck
	a_pixel_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && step.hit && valid_s2 && out_stall |-> !advance && in_stall)
		else $error("pixel advanced over a stalled output word");

	// A stuck output word keeps its value
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(pix_s2))
		else $error("output word changed while stalled");

endmodule

/* rtl/pgmp_parser.sv */
module pgmp_parser #(
	parameter int unsigned MAX_SIDE   = pgmp_pkg::MaxSideDefault,
	parameter int unsigned VALUE_BITS = pgmp_pkg::ValueBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          byte_in,
	input  logic                file_start,
	output pgmp_pkg::step_res_t res
);

	localparam int unsigned SW = $clog2(MAX_SIDE + 1);
	localparam int unsigned CW = $clog2(MAX_SIDE);
	localparam int unsigned AW = VALUE_BITS + 4;
	localparam logic [AW-1:0] VMAX_X = AW'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);

	typedef enum logic [3:0] {
		PH_SEEK = 4'b0001,
		PH_DIMS = 4'b0010,
		PH_MAXV = 4'b0100,
		PH_PIX  = 4'b1000
	} phase_t;

	phase_t                phase_q, ph;
	logic [1:0]            lpos_q, lp, lp_n;
	logic                  fwp_q, fwp;
	logic                  cmt_q, cm;
	logic [VALUE_BITS-1:0] acc_q, acc;
	logic                  have_q, have;
	logic [SW-1:0]         width_q, w;
	logic [SW-1:0]         height_q, h;
	logic [VALUE_BITS-1:0] maxv_q, mv;
	logic [CW-1:0]         col_q, col;
	logic [SW-1:0]         row_q, row;
	logic                  err_q, err;

	logic                  nl, digit, ws, had;
	logic [AW-1:0]         acc_x;
	logic [VALUE_BITS-1:0] value;
	logic [SW-1:0]         clamped, rowv;
	logic [31:0]           val_w, col_w, row_w, w_w, h_w, mv_w;

	always_comb begin
		ph   = file_start ? PH_SEEK : phase_q;
		lp   = file_start ? pgmp_pkg::LposStart : lpos_q;
		fwp  = file_start ? 1'b0 : fwp_q;
		cm   = file_start ? 1'b0 : cmt_q;
		acc  = file_start ? '0 : acc_q;
		have = file_start ? 1'b0 : have_q;
		w    = file_start ? '0 : width_q;
		h    = file_start ? '0 : height_q;
		mv   = file_start ? '0 : maxv_q;
		col  = file_start ? '0 : col_q;
		row  = file_start ? '0 : row_q;
		err  = file_start ? 1'b0 : err_q;

		nl    = (byte_in == pgmp_pkg::ChNewline);
		digit = (byte_in >= pgmp_pkg::ChZero) && (byte_in <= pgmp_pkg::ChNine);
		ws    = (byte_in == pgmp_pkg::ChSpace) || (byte_in == pgmp_pkg::ChTab) ||
		        nl || (byte_in == pgmp_pkg::ChVtab) || (byte_in == pgmp_pkg::ChFfeed) ||
		        (byte_in == pgmp_pkg::ChCr);

		if (nl) begin
			lp_n = pgmp_pkg::LposStart;
		end else if (lp == pgmp_pkg::LposStart) begin
			lp_n = pgmp_pkg::LposSecond;
		end else begin
			lp_n = pgmp_pkg::LposRest;
		end

		acc_x   = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(byte_in - pgmp_pkg::ChZero);
		value   = acc;
		had     = have;
		clamped = '0;
		rowv    = '0;
		res     = '0;

		if (lp == pgmp_pkg::LposStart && byte_in == pgmp_pkg::ChHash) begin
			cm = 1'b1;
		end

		if (cm) begin
			// skip the rest of a comment or magic line
			if (nl) begin
				cm = 1'b0;
			end
		end else if (ph == PH_SEEK) begin
			if (lp == pgmp_pkg::LposStart) begin
				fwp = (byte_in == pgmp_pkg::ChP);
			end else if (lp == pgmp_pkg::LposSecond && fwp && byte_in == pgmp_pkg::ChTwo) begin
				ph = PH_DIMS;
				cm = 1'b1;
			end
		end else if (digit) begin
			if (acc_x > VMAX_X) begin
				acc = VMAX_X[VALUE_BITS-1:0];
				err = 1'b1;
			end else begin
				acc = acc_x[VALUE_BITS-1:0];
			end
			have = 1'b1;
		end else if (!ws) begin
			err = 1'b1;
		end else begin
			acc  = '0;
			have = 1'b0;
			if (33'(value) > 33'(MAX_SIDE)) begin
				clamped = SIDE_MAX;
			end else begin
				clamped = SW'(value);
			end
			unique case (ph)
				PH_DIMS: begin
					if (had && value != '0) begin
						if (w == '0) begin
							w = clamped;
							if (33'(value) > 33'(MAX_SIDE)) err = 1'b1;
						end else if (h == '0) begin
							h = clamped;
							if (33'(value) > 33'(MAX_SIDE)) err = 1'b1;
						end
					end
					if (nl && (w != '0 || h != '0)) begin
						ph = PH_MAXV;
					end
				end
				PH_MAXV: begin
					if (had && mv == '0) begin
						mv = value;
					end
					if (nl && mv != '0) begin
						ph = PH_PIX;
					end
				end
				PH_PIX: begin
					if (had) begin
						if (row < h) begin
							rowv = row;
						end else begin
							rowv = (h != '0) ? h - 1'b1 : '0;
							err  = 1'b1;
						end
						res.hit = 1'b1;
						// wrap the column at the width
						if (SW'(col) + 1'b1 >= w) begin
							col = '0;
							if (row < SIDE_MAX) begin
								row = row + 1'b1;
							end
						end else begin
							col = col + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		val_w = 32'(value);
		col_w = file_start ? 32'd0 : 32'(col_q);
		row_w = 32'(rowv);
		w_w   = 32'(w);
		h_w   = 32'(h);
		mv_w  = 32'(mv);
		res.pix.pixel_value  = val_w[15:0];
		res.pix.column       = col_w[11:0];
		res.pix.row          = row_w[11:0];
		res.pix.image_width  = w_w[12:0];
		res.pix.image_height = h_w[12:0];
		res.pix.max_grey     = mv_w[15:0];
		res.pix.error_flag   = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			lpos_q   <= pgmp_pkg::LposStart;
			fwp_q    <= 1'b0;
			cmt_q    <= 1'b0;
			acc_q    <= '0;
			have_q   <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			maxv_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			err_q    <= 1'b0;
		end else if (en) begin
			phase_q  <= ph;
			lpos_q   <= lp_n;
			fwp_q    <= fwp;
			cmt_q    <= cm;
			acc_q    <= acc;
			have_q   <= have;
			width_q  <= w;
			height_q <= h;
			maxv_q   <= mv;
			col_q    <= col;
			row_q    <= row;
			err_q    <= err;
		end
	end

endmodule
